[hw/rtl/cdtp_pkg.sv]
// shared widths, codes and result types of the cnf token parser
`default_nettype none

package cdtp_pkg;

    // field widths
    localparam int INDEX_BITS = 31;
    localparam int LINE_BITS  = 24;
    localparam int KIND_BITS  = 2;
    localparam int ERR_BITS   = 3;
    localparam int FOUND_BITS = 9;
    localparam int BYTE_BITS  = 8;

    // stream widths: payload packed from the lowest bit, padded to bytes
    localparam int PAYLOAD_BITS = 1 + INDEX_BITS + 1 + 1 + ERR_BITS + FOUND_BITS + LINE_BITS;
    localparam int TDATA_BITS   = ((PAYLOAD_BITS + 7) / 8) * 8;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    typedef logic [KIND_BITS-1:0]  t_kind;
    typedef logic [ERR_BITS-1:0]   t_err;
    typedef logic [FOUND_BITS-1:0] t_found;

    // token kinds
    localparam t_kind KIND_LITERAL    = 2'd0;
    localparam t_kind KIND_CLAUSE_END = 2'd1;
    localparam t_kind KIND_ERROR      = 2'd2;
    localparam t_kind KIND_FINISHED   = 2'd3;

    // error codes
    localparam t_err ERR_NONE        = 3'd0;
    localparam t_err ERR_DIGIT       = 3'd1;
    localparam t_err ERR_EMPTY       = 3'd2;
    localparam t_err ERR_NO_ZERO     = 3'd3;
    localparam t_err ERR_NO_CLAUSES  = 3'd4;
    localparam t_err ERR_OVERFLOW    = 3'd5;

    // found byte value that stands for end of text
    localparam t_found FOUND_END = 9'd256;

    // characters
    localparam logic [BYTE_BITS-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_BITS-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_BITS-1:0] CH_VT    = 8'h0B;
    localparam logic [BYTE_BITS-1:0] CH_FF    = 8'h0C;
    localparam logic [BYTE_BITS-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_BITS-1:0] CH_C     = 8'h63;
    localparam logic [BYTE_BITS-1:0] CH_P     = 8'h70;
    localparam logic [BYTE_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_BITS-1:0] CH_NINE  = 8'h39;

    // payload, first member in the highest bits so negated lands at bit 0
    typedef struct packed {
        logic [LINE_BITS-1:0]  line;
        t_found                found;
        t_err                  err;
        logic                  conj;
        logic                  first;
        logic [INDEX_BITS-1:0] idx;
        logic                  neg;
    } t_payload;

    typedef struct packed {
        t_kind    kind;
        logic     last;
        t_payload data;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/cnf_dimacs_token_parser_top.sv]
// cnf token parser top level: byte stream in, literal and clause tokens out
// each result is written into the registered result queue by the byte transfer that causes it
// throughput: one byte per cycle while the queue has room; end of text may give two results
// the input stalls only while the four-entry result queue holds more than two results
// reset (synchronous, active low) clears the parse state, sets the line counter to one
// and empties the result queue; errors and end of text halt the parser until reset
`default_nettype none

module cnf_dimacs_token_parser_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input stream
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [cdtp_pkg::BYTE_BITS-1:0]  i_s_tdata,   // text_byte
    input  wire logic                            i_s_tuser,   // end_of_input
    // result stream
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // negated, variable_index, first_in_clause, needs_conjunction, error_code,
    // found_byte, line_number, zero padding
    output logic [cdtp_pkg::TDATA_BITS-1:0]      o_m_tdata,
    output logic [cdtp_pkg::KIND_BITS-1:0]       o_m_tuser,   // token_kind
    output logic                                 o_m_tlast    // last
);

    localparam int IDX = cdtp_pkg::INDEX_BITS;

    // parse modes
    localparam logic [2:0] M_START    = 3'd0;
    localparam logic [2:0] M_SKIPLINE = 3'd1;
    localparam logic [2:0] M_SIGNED   = 3'd2;
    localparam logic [2:0] M_NUMBER   = 3'd3;
    localparam logic [2:0] M_HALT     = 3'd4;

    // parse state
    logic [2:0]                      r_mode,  n_mode;
    logic                            r_minus, n_minus;
    logic [IDX-1:0]                  r_acc,   n_acc;
    logic                            r_open,  n_open;
    logic                            r_seen,  n_seen;
    logic [cdtp_pkg::LINE_BITS-1:0]  r_line,  n_line;

    // result queue
    cdtp_pkg::t_result               r_q [cdtp_pkg::QUEUE_DEPTH];
    logic [cdtp_pkg::PTR_BITS-1:0]   r_wr, r_rd;
    logic [cdtp_pkg::CNT_BITS-1:0]   r_count;

    logic                            w_in_xfer, w_out_xfer;
    logic                            w_digit, w_space, w_overflow;
    logic [3:0]                      w_d;
    logic [IDX+3:0]                  w_prod;
    logic [cdtp_pkg::LINE_BITS-1:0]  w_line;
    cdtp_pkg::t_result               w_tok, res0, res1;
    logic                            w_tok_ok, w_tok_open, w_tok_seen;
    logic [1:0]                      n_push;

    // error result with the given code and found byte
    function automatic cdtp_pkg::t_result make_error(
        input cdtp_pkg::t_err              err,
        input cdtp_pkg::t_found            found,
        input logic [cdtp_pkg::LINE_BITS-1:0] line
    );
        cdtp_pkg::t_result r;
        r            = '0;
        r.kind       = cdtp_pkg::KIND_ERROR;
        r.data.err   = err;
        r.data.found = found;
        r.data.line  = line;
        return r;
    endfunction

    // end-of-text result from the clause flags
    function automatic cdtp_pkg::t_result finish_res(
        input logic                        open,
        input logic                        seen,
        input logic [cdtp_pkg::LINE_BITS-1:0] line
    );
        cdtp_pkg::t_result r;
        if (open) begin
            r = make_error(cdtp_pkg::ERR_NO_ZERO, '0, line);
        end else if (!seen) begin
            r = make_error(cdtp_pkg::ERR_NO_CLAUSES, '0, line);
        end else begin
            r           = '0;
            r.kind      = cdtp_pkg::KIND_FINISHED;
            r.data.line = line;
        end
        return r;
    endfunction

    assign w_in_xfer  = i_s_tvalid && o_s_tready;
    assign w_out_xfer = o_m_tvalid && i_m_tready;

    // halted parser swallows everything; otherwise room for two results is needed
    assign o_s_tready = (r_mode == M_HALT) ||
                        (r_count <= cdtp_pkg::CNT_BITS'(cdtp_pkg::QUEUE_DEPTH - 2));

    // character classes
    assign w_digit = i_s_tdata inside {[cdtp_pkg::CH_ZERO:cdtp_pkg::CH_NINE]};
    assign w_space = i_s_tdata inside {cdtp_pkg::CH_SPACE, cdtp_pkg::CH_TAB, cdtp_pkg::CH_LF,
                                       cdtp_pkg::CH_VT, cdtp_pkg::CH_FF, cdtp_pkg::CH_CR};
    assign w_d     = 4'(i_s_tdata - cdtp_pkg::CH_ZERO);

    // acc * 10 + digit, overflow when any bit above the index width is set
    assign w_prod     = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                      + {{IDX{1'b0}}, w_d};
    assign w_overflow = |w_prod[IDX+3:IDX];

    // line counter after this byte, saturating
    assign w_line = (!i_s_tuser && i_s_tdata == cdtp_pkg::CH_LF && r_line != '1)
                  ? r_line + cdtp_pkg::LINE_BITS'(1) : r_line;

    // token for a finished number
    always_comb begin
        w_tok      = '0;
        w_tok_ok   = 1'b1;
        w_tok_open = r_open;
        w_tok_seen = r_seen;
        w_tok.data.line = w_line;
        if (r_acc != '0) begin
            w_tok.kind       = cdtp_pkg::KIND_LITERAL;
            w_tok.data.neg   = r_minus;
            w_tok.data.idx   = r_acc;
            w_tok.data.first = !r_open;
            w_tok.data.conj  = !r_open && r_seen;
            w_tok_open       = 1'b1;
        end else if (r_open) begin
            w_tok.kind = cdtp_pkg::KIND_CLAUSE_END;
            w_tok_open = 1'b0;
            w_tok_seen = 1'b1;
        end else begin
            w_tok    = make_error(cdtp_pkg::ERR_EMPTY, '0, w_line);
            w_tok_ok = 1'b0;
        end
    end

    // parser next state and results of the current transfer
    always_comb begin
        n_mode  = r_mode;
        n_minus = r_minus;
        n_acc   = r_acc;
        n_open  = r_open;
        n_seen  = r_seen;
        n_line  = r_line;
        res0    = '0;
        res1    = '0;
        n_push  = 2'd0;
        if (w_in_xfer && r_mode != M_HALT) begin
            n_line = w_line;
            if (i_s_tuser) begin
                n_mode = M_HALT;
                if (r_mode == M_SIGNED) begin
                    res0   = make_error(cdtp_pkg::ERR_DIGIT, cdtp_pkg::FOUND_END, w_line);
                    n_push = 2'd1;
                end else if (r_mode == M_NUMBER) begin
                    res0   = w_tok;
                    n_open = w_tok_open;
                    n_seen = w_tok_seen;
                    if (w_tok_ok) begin
                        res1   = finish_res(w_tok_open, w_tok_seen, w_line);
                        n_push = 2'd2;
                    end else begin
                        n_push = 2'd1;
                    end
                end else begin
                    res0   = finish_res(r_open, r_seen, w_line);
                    n_push = 2'd1;
                end
            end else begin
                case (r_mode)
                    M_START: begin
                        if (w_space) begin
                            n_mode = M_START;
                        end else if (i_s_tdata == cdtp_pkg::CH_C ||
                                     i_s_tdata == cdtp_pkg::CH_P) begin
                            n_mode = M_SKIPLINE;
                        end else if (i_s_tdata == cdtp_pkg::CH_MINUS) begin
                            n_minus = 1'b1;
                            n_mode  = M_SIGNED;
                        end else if (w_digit) begin
                            n_minus = 1'b0;
                            n_acc   = IDX'(w_d);
                            n_mode  = M_NUMBER;
                        end else begin
                            res0   = make_error(cdtp_pkg::ERR_DIGIT, {1'b0, i_s_tdata},
                                                w_line);
                            n_push = 2'd1;
                            n_mode = M_HALT;
                        end
                    end
                    M_SKIPLINE: begin
                        if (i_s_tdata == cdtp_pkg::CH_LF) begin
                            n_mode = M_START;
                        end
                    end
                    M_SIGNED: begin
                        if (w_digit) begin
                            n_acc  = IDX'(w_d);
                            n_mode = M_NUMBER;
                        end else begin
                            res0   = make_error(cdtp_pkg::ERR_DIGIT, {1'b0, i_s_tdata},
                                                w_line);
                            n_push = 2'd1;
                            n_mode = M_HALT;
                        end
                    end
                    M_NUMBER: begin
                        if (w_digit) begin
                            if (w_overflow) begin
                                res0   = make_error(cdtp_pkg::ERR_OVERFLOW, '0, w_line);
                                n_push = 2'd1;
                                n_mode = M_HALT;
                            end else begin
                                n_acc = w_prod[IDX-1:0];
                            end
                        end else begin
                            // terminating byte is consumed with the token
                            res0   = w_tok;
                            n_push = 2'd1;
                            n_open = w_tok_open;
                            n_seen = w_tok_seen;
                            n_mode = w_tok_ok ? M_START : M_HALT;
                        end
                    end
                    default: begin
                        n_mode = r_mode;
                    end
                endcase
            end
        end
        // mark the last result of this transfer
        if (n_push == 2'd1) begin
            res0.last = 1'b1;
        end else if (n_push == 2'd2) begin
            res1.last = 1'b1;
        end
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_START;
            r_minus <= 1'b0;
            r_acc   <= '0;
            r_open  <= 1'b0;
            r_seen  <= 1'b0;
            r_line  <= cdtp_pkg::LINE_BITS'(1);
        end else begin
            r_mode  <= n_mode;
            r_minus <= n_minus;
            r_acc   <= n_acc;
            r_open  <= n_open;
            r_seen  <= n_seen;
            r_line  <= n_line;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + cdtp_pkg::PTR_BITS'(n_push);
            r_count <= r_count + cdtp_pkg::CNT_BITS'(n_push)
                     - cdtp_pkg::CNT_BITS'(w_out_xfer);
            if (w_out_xfer) begin
                r_rd <= r_rd + cdtp_pkg::PTR_BITS'(1);
            end
        end
    end

    // queue entries
    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_q[r_wr] <= res0;
        end
        if (n_push == 2'd2) begin
            r_q[r_wr + cdtp_pkg::PTR_BITS'(1)] <= res1;
        end
    end

    // result stream outputs
    assign o_m_tvalid = (r_count != '0);
    assign o_m_tdata  = cdtp_pkg::TDATA_BITS'(r_q[r_rd].data);
    assign o_m_tuser  = r_q[r_rd].kind;
    assign o_m_tlast  = r_q[r_rd].last;

    // checks
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_push != 2'd0) |->
            ((r_count + cdtp_pkg::CNT_BITS'(n_push)) <=
             cdtp_pkg::CNT_BITS'(cdtp_pkg::QUEUE_DEPTH)))
        else $error("result queue overrun");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_HALT) |=> (r_mode == M_HALT))
        else $error("parser left halt without reset");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_HALT) |-> (n_push == 2'd0))
        else $error("halted parser produced a result");

    a_end_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_s_tuser && r_mode != M_HALT) |=> (r_mode == M_HALT))
        else $error("end of text did not halt the parser");

    a_found_only_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != cdtp_pkg::KIND_ERROR) |->
            (r_q[r_rd].data.found == '0))
        else $error("found byte set on a non-error result");

endmodule

`default_nettype wire
